>>> rtl/security_association_table_assert.svh
// Assertion macros for the security association table.
`ifndef SECURITY_ASSOCIATION_TABLE_ASSERT_SVH
`define SECURITY_ASSOCIATION_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SAT_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("sat assertion failed");

`define SAT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("sat assertion failed");

`else

`define SAT_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons)

`define SAT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

>>> rtl/sat_pkg.sv
package sat_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int SPI_W       = 16;

  localparam logic [0:0] CFG_UNIQUE_PER_MAP  = 1'd0;
  localparam logic [0:0] CFG_SEGMENT_HEADERS = 1'd1;

  localparam logic [3:0] STAT_OK        = 4'd0;
  localparam logic [3:0] STAT_BAD_SPI   = 4'd1;
  localparam logic [3:0] STAT_WRONG     = 4'd2;
  localparam logic [3:0] STAT_NO_MATCH  = 4'd3;
  localparam logic [3:0] STAT_TFVN      = 4'd4;
  localparam logic [3:0] STAT_SCID      = 4'd5;
  localparam logic [3:0] STAT_VCID      = 4'd6;
  localparam logic [3:0] STAT_MAPID     = 4'd7;
  localparam logic [3:0] STAT_NOT_OPER  = 4'd8;

  typedef enum logic [2:0] {
    MODE_CREATE = 3'd0,
    MODE_REKEY  = 3'd1,
    MODE_START  = 3'd2,
    MODE_STOP   = 3'd3,
    MODE_EXPIRE = 3'd4,
    MODE_DELETE = 3'd5,
    MODE_LOOKUP = 3'd6,
    MODE_STATUS = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    SA_NONE   = 2'd0,
    SA_NOKEY  = 2'd1,
    SA_HASKEY = 2'd2,
    SA_OPER   = 2'd3
  } sa_state_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_SCAN = 2'd1,
    FSM_HOLD = 2'd2
  } fsm_t;

  typedef struct packed {
    sa_state_t   state;
    logic        enc;
    logic        auth;
    logic [15:0] key;
    logic [1:0]  tfvn;
    logic [9:0]  scid;
    logic [5:0]  vcid;
    logic [5:0]  mapid;
    logic [7:0]  lpid;
  } entry_t;

  typedef struct packed {
    mode_t            mode;
    logic [SPI_W-1:0] spi;
    logic [1:0]       tfvn;
    logic [9:0]       scid;
    logic [5:0]       vcid;
    logic [5:0]       mapid;
    logic [7:0]       pdu;
    logic             enc;
    logic             auth;
    logic [15:0]      key;
  } req_t;

  typedef struct packed {
    logic unique_per_map;
    logic segment_headers;
  } cfg_t;

  typedef struct packed {
    logic             hit;
    logic [3:0]       code;
    logic [IDX_W-1:0] idx;
    logic [7:0]       lpid;
    sa_state_t        state;
    logic [15:0]      key;
    logic             enc;
    logic             auth;
  } res_t;

  localparam res_t RES_INIT = '{hit: 1'b0, code: STAT_NO_MATCH, idx: '0, lpid: '0,
                                state: SA_NONE, key: '0, enc: 1'b0, auth: 1'b0};

  function automatic sa_state_t need_state(mode_t m);
    sa_state_t s;
    case (m)
      MODE_CREATE: s = SA_NONE;
      MODE_REKEY:  s = SA_NOKEY;
      MODE_START:  s = SA_HASKEY;
      MODE_STOP:   s = SA_OPER;
      MODE_EXPIRE: s = SA_HASKEY;
      default:     s = SA_NOKEY;
    endcase
    return s;
  endfunction

  function automatic sa_state_t next_state(mode_t m);
    sa_state_t s;
    case (m)
      MODE_CREATE: s = SA_NOKEY;
      MODE_REKEY:  s = SA_HASKEY;
      MODE_START:  s = SA_OPER;
      MODE_STOP:   s = SA_HASKEY;
      MODE_EXPIRE: s = SA_NOKEY;
      default:     s = SA_NONE;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/security_association_table.sv
// Security association table: one entry per cell in a row of NUM_ENTRIES
// cells. Every item (command, status query or channel lookup) is carried
// through the row one cell per clock: it is registered into the start flag,
// then through each cell register, into the result hold register and then
// into the output register; the next item can be accepted once the result
// has moved to the output register. One item is in flight at a time, and the
// finished result sits in the output register while the next item is taken;
// a result that is not taken holds the following one back. Every item gives
// exactly one result.
// Configuration writes take effect at once.
module security_association_table
  import sat_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [0:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [15:0] spi,
  input  logic [1:0]  frame_version,
  input  logic [9:0]  craft_id,
  input  logic [5:0]  channel_id,
  input  logic [5:0]  map_id,
  input  logic [7:0]  pdu_id,
  input  logic        enc_flag,
  input  logic        auth_flag,
  input  logic [15:0] key_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [5:0]  found_spi,
  output logic [7:0]  last_pdu,
  output logic [1:0]  entry_state,
  output logic [15:0] entry_key,
  output logic        entry_enc,
  output logic        entry_auth
);

  `include "security_association_table_assert.svh"

  fsm_t state;
  fsm_t state_next;
  cfg_t cfg;
  req_t req;
  res_t res_hold;
  res_t fin;
  logic start;
  logic accept;
  logic xfer;
  logic scan_done;
  logic spi_bad;

  logic [NUM_ENTRIES:0] tok;
  res_t                 res_chain [NUM_ENTRIES+1];

  assign tok[0]       = start;
  assign res_chain[0] = RES_INIT;
  assign scan_done    = tok[NUM_ENTRIES];

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
    sat_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IDX_W'(g)),
      .cfg     (cfg),
      .req     (req),
      .tok_in  (tok[g]),
      .res_in  (res_chain[g]),
      .tok_out (tok[g+1]),
      .res_out (res_chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UNIQUE_PER_MAP:  cfg.unique_per_map  <= cfg_data[0];
        CFG_SEGMENT_HEADERS: cfg.segment_headers <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: if (in_valid) state_next = FSM_SCAN;
      FSM_SCAN: if (scan_done) state_next = FSM_HOLD;
      FSM_HOLD: if (!out_valid || out_ready) state_next = FSM_IDLE;
      default:  state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == FSM_IDLE);
    accept   = in_ready && in_valid;
    xfer     = (state == FSM_HOLD) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept;
      if (xfer) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.mode  <= mode_t'(mode);
      req.spi   <= spi;
      req.tfvn  <= frame_version;
      req.scid  <= craft_id;
      req.vcid  <= channel_id;
      req.mapid <= map_id;
      req.pdu   <= pdu_id;
      req.enc   <= enc_flag;
      req.auth  <= auth_flag;
      req.key   <= key_id;
    end
    if (scan_done) begin
      res_hold <= res_chain[NUM_ENTRIES];
    end
  end

  assign spi_bad = (req.mode != MODE_LOOKUP) && (req.spi >= SPI_W'(NUM_ENTRIES));

  always_comb begin
    fin = res_hold;
    if (spi_bad) begin
      fin      = RES_INIT;
      fin.code = STAT_BAD_SPI;
    end else if (!res_hold.hit) begin
      fin      = RES_INIT;
      fin.code = res_hold.code;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      status      <= fin.code;
      found_spi   <= 6'(fin.idx);
      last_pdu    <= fin.lpid;
      entry_state <= fin.state;
      entry_key   <= fin.key;
      entry_enc   <= fin.enc;
      entry_auth  <= fin.auth;
    end
  end

  `SAT_ASSERT_NOW(a_one_token, clk, rst, state == FSM_SCAN, $onehot(tok))
  `SAT_ASSERT_NOW(a_no_token_idle, clk, rst, state != FSM_SCAN, tok == '0)
  `SAT_ASSERT_NEXT(a_accept_starts, clk, rst, accept, start && state == FSM_SCAN)
  `SAT_ASSERT_NOW(a_bad_spi_clean, clk, rst, out_valid && status == STAT_BAD_SPI,
                  found_spi == '0 && entry_state == '0 && entry_key == '0)

endmodule

>>> rtl/sat_cell.sv
module sat_cell
  import sat_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  cfg_t             cfg,
  input  req_t             req,
  input  logic             tok_in,
  input  res_t             res_in,
  output logic             tok_out,
  output res_t             res_out
);

  entry_t ent;
  entry_t ent_next;
  res_t   res_next;
  logic   t, s, v, m, o;

  function automatic res_t fill(res_t r, entry_t e);
    res_t x;
    x       = r;
    x.lpid  = e.lpid;
    x.state = e.state;
    x.key   = e.key;
    x.enc   = e.enc;
    x.auth  = e.auth;
    return x;
  endfunction

  always_comb begin
    ent_next = ent;
    res_next = res_in;
    t = (ent.tfvn == req.tfvn);
    s = (ent.scid == req.scid);
    v = (ent.vcid == req.vcid);
    m = (ent.mapid == req.mapid);
    o = (ent.state == SA_OPER);
    if (req.mode == MODE_LOOKUP) begin
      if (!res_in.hit) begin
        if (o && t && s && v && (!cfg.unique_per_map || m)) begin
          res_next      = fill(res_in, ent);
          res_next.hit  = 1'b1;
          res_next.code = STAT_OK;
          res_next.idx  = idx;
        end else if (!t && s && v && m && o) begin
          res_next.code = STAT_TFVN;
        end else if (t && !s && v && m && o) begin
          res_next.code = STAT_SCID;
        end else if (t && s && !v && m && o) begin
          res_next.code = STAT_VCID;
        end else if (t && s && v && !m && o) begin
          res_next.code = STAT_MAPID;
        end else if (t && s && v && m && !o) begin
          res_next.code = STAT_NOT_OPER;
        end
      end
    end else if (req.spi == SPI_W'(idx)) begin
      if (req.mode != MODE_STATUS) begin
        ent_next.lpid = req.pdu;
        if (ent.state == need_state(req.mode)) begin
          ent_next.state = next_state(req.mode);
          case (req.mode)
            MODE_CREATE: begin
              ent_next.enc  = req.enc;
              ent_next.auth = req.auth;
            end
            MODE_REKEY: begin
              ent_next.key = req.key;
            end
            MODE_START: begin
              ent_next.tfvn  = req.tfvn;
              ent_next.scid  = req.scid;
              ent_next.vcid  = req.vcid;
              ent_next.mapid = cfg.segment_headers ? req.mapid : 6'd0;
            end
            MODE_STOP: begin
              ent_next.tfvn  = '0;
              ent_next.scid  = '0;
              ent_next.vcid  = '0;
              ent_next.mapid = '0;
            end
            default: begin
            end
          endcase
        end
      end
      res_next      = fill(res_in, ent_next);
      res_next.hit  = 1'b1;
      res_next.idx  = idx;
      res_next.code = (req.mode == MODE_STATUS || ent.state == need_state(req.mode))
                      ? STAT_OK : STAT_WRONG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent     <= '{state: SA_NONE, enc: 1'b0, auth: 1'b0, key: 16'(idx),
                   tfvn: 2'd0, scid: 10'd0, vcid: 6'd0, mapid: 6'd0, lpid: 8'd0};
      tok_out <= 1'b0;
    end else begin
      if (tok_in) begin
        ent <= ent_next;
      end
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    res_out <= res_next;
  end

endmodule

>>> tb/tb_security_association_table.sv
`timescale 1ns / 100ps

module tb_security_association_table
  import sat_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic [3:0]  status;
    logic [5:0]  idx;
    logic [7:0]  lpid;
    logic [1:0]  state;
    logic [15:0] key;
    logic        enc;
    logic        auth;
  } sa_reply_t;

  class sa_scoreboard;
    entry_t      sa_tab[NUM_ENTRIES];
    bit          per_map;
    bit          keep_map;
    sa_reply_t   expected_q[$];
    int          errors;
    int          results;

    function new();
      int i;
      for (i = 0; i < NUM_ENTRIES; i++) begin
        sa_tab[i] = '0;
        sa_tab[i].state = SA_NONE;
        sa_tab[i].key = 16'(i);
      end
      per_map = 1'b0;
      keep_map = 1'b0;
      errors = 0;
      results = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic val);
      if (idx == CFG_UNIQUE_PER_MAP) per_map = val;
      else keep_map = val;
    endfunction

    function sa_reply_t entry_reply(logic [3:0] st, int idx);
      sa_reply_t rep;
      rep.status = st;
      rep.idx = 6'(idx);
      rep.lpid = sa_tab[idx].lpid;
      rep.state = sa_tab[idx].state;
      rep.key = sa_tab[idx].key;
      rep.enc = sa_tab[idx].enc;
      rep.auth = sa_tab[idx].auth;
      return rep;
    endfunction

    // Work out the reply to one accepted item and advance the table.
    function void note_item(req_t r);
      sa_reply_t rep;
      sa_state_t need, nxt;
      logic [3:0] code;
      bit hit, t, s, v, m, o;
      int i;
      rep = '0;
      if (r.mode == MODE_LOOKUP) begin
        hit = 1'b0;
        code = STAT_NO_MATCH;
        for (i = 0; i < NUM_ENTRIES && !hit; i++) begin
          if (sa_tab[i].state == SA_OPER && sa_tab[i].tfvn == r.tfvn &&
              sa_tab[i].scid == r.scid && sa_tab[i].vcid == r.vcid &&
              (!per_map || sa_tab[i].mapid == r.mapid)) begin
            hit = 1'b1;
            rep = entry_reply(STAT_OK, i);
          end
        end
        if (!hit) begin
          // highest index partial match decides the error
          for (i = 0; i < NUM_ENTRIES; i++) begin
            t = sa_tab[i].tfvn == r.tfvn;
            s = sa_tab[i].scid == r.scid;
            v = sa_tab[i].vcid == r.vcid;
            m = sa_tab[i].mapid == r.mapid;
            o = sa_tab[i].state == SA_OPER;
            if (!t && s && v && m && o) code = STAT_TFVN;
            if (t && !s && v && m && o) code = STAT_SCID;
            if (t && s && !v && m && o) code = STAT_VCID;
            if (t && s && v && !m && o) code = STAT_MAPID;
            if (t && s && v && m && !o) code = STAT_NOT_OPER;
          end
          rep.status = code;
        end
      end else if (r.spi >= NUM_ENTRIES) begin
        rep.status = STAT_BAD_SPI;
      end else if (r.mode == MODE_STATUS) begin
        rep = entry_reply(STAT_OK, int'(r.spi));
      end else begin
        i = int'(r.spi);
        case (r.mode)
          MODE_CREATE: begin need = SA_NONE;   nxt = SA_NOKEY;  end
          MODE_REKEY:  begin need = SA_NOKEY;  nxt = SA_HASKEY; end
          MODE_START:  begin need = SA_HASKEY; nxt = SA_OPER;   end
          MODE_STOP:   begin need = SA_OPER;   nxt = SA_HASKEY; end
          MODE_EXPIRE: begin need = SA_HASKEY; nxt = SA_NOKEY;  end
          default:     begin need = SA_NOKEY;  nxt = SA_NONE;   end
        endcase
        sa_tab[i].lpid = r.pdu;
        if (sa_tab[i].state != need) begin
          rep = entry_reply(STAT_WRONG, i);
        end else begin
          case (r.mode)
            MODE_CREATE: begin
              sa_tab[i].enc = r.enc;
              sa_tab[i].auth = r.auth;
            end
            MODE_REKEY: sa_tab[i].key = r.key;
            MODE_START: begin
              sa_tab[i].tfvn = r.tfvn;
              sa_tab[i].scid = r.scid;
              sa_tab[i].vcid = r.vcid;
              sa_tab[i].mapid = keep_map ? r.mapid : 6'd0;
            end
            MODE_STOP: begin
              sa_tab[i].tfvn = '0;
              sa_tab[i].scid = '0;
              sa_tab[i].vcid = '0;
              sa_tab[i].mapid = '0;
            end
            default: ;
          endcase
          sa_tab[i].state = nxt;
          rep = entry_reply(STAT_OK, i);
        end
      end
      expected_q.push_back(rep);
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(sa_reply_t got);
      sa_reply_t want;
      results++;
      if (expected_q.size() == 0) begin
        $error("result with nothing pending: status %0d found_spi %0d", got.status, got.idx);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp_field("status", 16'(want.status), 16'(got.status));
      cmp_field("found_spi", 16'(want.idx), 16'(got.idx));
      cmp_field("last_pdu", 16'(want.lpid), 16'(got.lpid));
      cmp_field("entry_state", 16'(want.state), 16'(got.state));
      cmp_field("entry_key", want.key, got.key);
      cmp_field("entry_enc", 16'(want.enc), 16'(got.enc));
      cmp_field("entry_auth", 16'(want.auth), 16'(got.auth));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [0:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  mode = '0;
  logic [15:0] spi = '0;
  logic [1:0]  frame_version = '0;
  logic [9:0]  craft_id = '0;
  logic [5:0]  channel_id = '0;
  logic [5:0]  map_id = '0;
  logic [7:0]  pdu_id = '0;
  logic        enc_flag = 1'b0;
  logic        auth_flag = 1'b0;
  logic [15:0] key_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  status;
  logic [5:0]  found_spi;
  logic [7:0]  last_pdu;
  logic [1:0]  entry_state;
  logic [15:0] entry_key;
  logic        entry_enc;
  logic        entry_auth;

  sa_scoreboard sb = new();
  int unsigned  cycles = 0;
  int           burst_left = 0;
  bit           long_hold_done = 1'b0;

  logic [1:0]   pool_tf[4];
  logic [9:0]   pool_sc[4];
  logic [5:0]   pool_vc[4];
  logic [5:0]   pool_mp[4];

  security_association_table u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .spi(spi), .frame_version(frame_version), .craft_id(craft_id),
    .channel_id(channel_id), .map_id(map_id), .pdu_id(pdu_id),
    .enc_flag(enc_flag), .auth_flag(auth_flag), .key_id(key_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .found_spi(found_spi), .last_pdu(last_pdu),
    .entry_state(entry_state), .entry_key(entry_key),
    .entry_enc(entry_enc), .entry_auth(entry_auth)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles == CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({status, found_spi, last_pdu, entry_state, entry_key,
                       entry_enc, entry_auth});
  end

  // Receiver: random stall patterns, plus one long hold-off so the table backs up.
  initial begin
    int pat;
    int left;
    int k;
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && sb.results >= 120) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        long_hold_done = 1'b1;
      end
      pat = $urandom_range(0, 3);
      left = $urandom_range(10, 300);
      for (k = 0; k < left; k++) begin
        case (pat)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (k % 7) < 3;
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic req_t mk(mode_t md, logic [15:0] sp, logic [1:0] tf, logic [9:0] sc,
                              logic [5:0] vc, logic [5:0] mp, logic [7:0] pdu,
                              logic en, logic au, logic [15:0] key);
    req_t r;
    r.mode = md;
    r.spi = sp;
    r.tfvn = tf;
    r.scid = sc;
    r.vcid = vc;
    r.mapid = mp;
    r.pdu = pdu;
    r.enc = en;
    r.auth = au;
    r.key = key;
    return r;
  endfunction

  function automatic void refresh_chan(int slot);
    pool_tf[slot] = 2'($urandom);
    pool_sc[slot] = 10'($urandom);
    pool_vc[slot] = 6'($urandom);
    pool_mp[slot] = $urandom_range(0, 1) ? 6'($urandom) : 6'd0;
  endfunction

  // Mostly legal lifecycle steps on a few channels, with lookups, queries and noise.
  function automatic req_t rand_item();
    req_t r;
    int sel;
    int slot;
    sa_state_t st;
    sel = $urandom_range(0, 99);
    if (sel < 10) r.spi = 16'($urandom_range(64, 65535));
    else if (sel < 70) r.spi = 16'($urandom_range(0, 15));
    else r.spi = 16'($urandom_range(0, NUM_ENTRIES - 1));
    slot = $urandom_range(0, 3);
    if ($urandom_range(0, 49) == 0) refresh_chan(slot);
    r.tfvn = pool_tf[slot];
    r.scid = pool_sc[slot];
    r.vcid = pool_vc[slot];
    r.mapid = pool_mp[slot];
    if ($urandom_range(0, 6) == 0) begin
      r.tfvn = 2'($urandom);
      r.scid = 10'($urandom);
      r.vcid = 6'($urandom);
      r.mapid = 6'($urandom);
    end
    r.pdu = 8'($urandom);
    r.enc = 1'($urandom);
    r.auth = 1'($urandom);
    r.key = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      r.mode = mode_t'($urandom_range(0, 7));
    end else if (sel < 32) begin
      r.mode = MODE_LOOKUP;
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: r.tfvn = r.tfvn ^ 2'($urandom_range(1, 3));
          1: r.scid = r.scid ^ 10'($urandom_range(1, 1023));
          2: r.vcid = r.vcid ^ 6'($urandom_range(1, 63));
          default: r.mapid = r.mapid ^ 6'($urandom_range(1, 63));
        endcase
      end
    end else if (sel < 40) begin
      r.mode = MODE_STATUS;
    end else begin
      st = (r.spi < NUM_ENTRIES) ? sb.sa_tab[r.spi[5:0]].state : SA_NONE;
      case (st)
        SA_NONE:   r.mode = MODE_CREATE;
        SA_NOKEY:  r.mode = ($urandom_range(0, 9) < 7) ? MODE_REKEY : MODE_DELETE;
        SA_HASKEY: r.mode = ($urandom_range(0, 9) < 7) ? MODE_START : MODE_EXPIRE;
        default:   r.mode = MODE_STOP;
      endcase
    end
    return r;
  endfunction

  task automatic offer(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 100);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    mode <= r.mode;
    spi <= r.spi;
    frame_version <= r.tfvn;
    craft_id <= r.scid;
    channel_id <= r.vcid;
    map_id <= r.mapid;
    pdu_id <= r.pdu;
    enc_flag <= r.enc;
    auth_flag <= r.auth;
    key_id <= r.key;
    do @(posedge clk); while (!in_ready);
    sb.note_item(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_cfg(input logic per_map, input logic keep_map);
    cfg_we <= 1'b1;
    cfg_index <= CFG_UNIQUE_PER_MAP;
    cfg_data <= per_map;
    @(posedge clk);
    sb.set_reg(CFG_UNIQUE_PER_MAP, per_map);
    cfg_index <= CFG_SEGMENT_HEADERS;
    cfg_data <= keep_map;
    @(posedge clk);
    sb.set_reg(CFG_SEGMENT_HEADERS, keep_map);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int ph;
    int n;
    for (n = 0; n < 4; n++) refresh_chan(n);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_cfg(1'b0, 1'b0);
    offer(mk(MODE_STATUS, 16'd63, 2'd0, 10'd0, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0, 16'h0000));
    offer(mk(MODE_CREATE, 16'd0, 2'd0, 10'd0, 6'd0, 6'd0, 8'hFF, 1'b1, 1'b0, 16'h0000));
    offer(mk(MODE_CREATE, 16'd0, 2'd0, 10'd0, 6'd0, 6'd0, 8'h00, 1'b0, 1'b1, 16'h0000));
    offer(mk(MODE_REKEY, 16'd0, 2'd0, 10'd0, 6'd0, 6'd0, 8'h80, 1'b0, 1'b0, 16'hFFFF));
    offer(mk(MODE_START, 16'd0, 2'd3, 10'd1023, 6'd63, 6'd63, 8'h40, 1'b1, 1'b1, 16'h0));
    // hit, then one channel field off at a time
    offer(mk(MODE_LOOKUP, 16'd0, 2'd3, 10'd1023, 6'd63, 6'd0, 8'h00, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_LOOKUP, 16'd0, 2'd2, 10'd1023, 6'd63, 6'd0, 8'h00, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_LOOKUP, 16'd0, 2'd3, 10'd0, 6'd63, 6'd0, 8'h00, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_LOOKUP, 16'd0, 2'd3, 10'd1023, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_LOOKUP, 16'hFFFF, 2'd3, 10'd1023, 6'd63, 6'd63, 8'hFF, 1'b1, 1'b1,
             16'hFFFF));
    offer(mk(MODE_CREATE, 16'd63, 2'd0, 10'd0, 6'd0, 6'd0, 8'h3F, 1'b0, 1'b1, 16'h0000));
    offer(mk(MODE_LOOKUP, 16'd0, 2'd0, 10'd0, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_LOOKUP, 16'd0, 2'd1, 10'd512, 6'd1, 6'd1, 8'h00, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_CREATE, 16'd64, 2'd0, 10'd0, 6'd0, 6'd0, 8'h11, 1'b1, 1'b1, 16'h0));
    offer(mk(MODE_STATUS, 16'hFFFF, 2'd0, 10'd0, 6'd0, 6'd0, 8'h22, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_REKEY, 16'h8000, 2'd0, 10'd0, 6'd0, 6'd0, 8'h33, 1'b0, 1'b0, 16'h5A5A));
    offer(mk(MODE_STOP, 16'd0, 2'd0, 10'd0, 6'd0, 6'd0, 8'h01, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_EXPIRE, 16'd0, 2'd0, 10'd0, 6'd0, 6'd0, 8'h02, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_DELETE, 16'd0, 2'd0, 10'd0, 6'd0, 6'd0, 8'h03, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_DELETE, 16'd0, 2'd0, 10'd0, 6'd0, 6'd0, 8'h04, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_START, 16'd63, 2'd1, 10'd1, 6'd1, 6'd1, 8'h05, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_EXPIRE, 16'd63, 2'd0, 10'd0, 6'd0, 6'd0, 8'h06, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_STATUS, 16'd0, 2'd0, 10'd0, 6'd0, 6'd0, 8'h07, 1'b0, 1'b0, 16'h0));
    drain();

    // map id kept on start and required by lookup
    set_cfg(1'b1, 1'b1);
    offer(mk(MODE_CREATE, 16'd5, 2'd0, 10'd0, 6'd0, 6'd0, 8'h10, 1'b1, 1'b1, 16'h0));
    offer(mk(MODE_REKEY, 16'd5, 2'd0, 10'd0, 6'd0, 6'd0, 8'h20, 1'b0, 1'b0, 16'h1234));
    offer(mk(MODE_START, 16'd5, 2'd1, 10'd300, 6'd20, 6'd45, 8'h30, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_LOOKUP, 16'd0, 2'd1, 10'd300, 6'd20, 6'd44, 8'h00, 1'b0, 1'b0, 16'h0));
    offer(mk(MODE_LOOKUP, 16'd0, 2'd1, 10'd300, 6'd20, 6'd45, 8'h00, 1'b0, 1'b0, 16'h0));

    for (ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: set_cfg(1'b1, 1'b1);
        1: set_cfg(1'b1, 1'b0);
        2: set_cfg(1'b0, 1'b1);
        3: set_cfg(1'b0, 1'b0);
        default: set_cfg(1'($urandom), 1'($urandom));
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) offer(rand_item());
    end

    drain();
    repeat (NUM_ENTRIES + 8) @(posedge clk);
    if (sb.expected_q.size() != 0)
      $error("%0d results never arrived", sb.expected_q.size());
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/sat_pkg.sv
rtl/sat_cell.sv
rtl/security_association_table.sv
tb/tb_security_association_table.sv
